>>> src/blp_pkg.sv
// blp_pkg: shared types, sizes and result codes for the bucketed list pool
// used by blp_ctrl, blp_dp and bucketed_list_pool; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package blp_pkg;

    localparam int HEADS     = 1024;
    localparam int EXTRA     = 7168;
    localparam int POOL      = HEADS + EXTRA;
    localparam int ADDR_W    = $clog2(POOL);
    localparam int NFREE_W   = $clog2(POOL + 1);
    localparam int HEAD_W    = (HEADS > 1) ? $clog2(HEADS) : 1;

    // item fields
    localparam int BKT_W     = 10;
    localparam int VAL_W     = 32;
    localparam int WGT_W     = 32;
    localparam int POS_W     = 13;
    localparam int STS_W     = 3;

    // input tdata layout, lowest bits first
    localparam int BKT_LSB   = 0;
    localparam int VAL_LSB   = BKT_LSB + BKT_W;
    localparam int WGT_LSB   = VAL_LSB + VAL_W;
    localparam int POS_LSB   = WGT_LSB + WGT_W;
    localparam int S_DATA_W  = ((POS_LSB + POS_W + 7) / 8) * 8;
    localparam int M_DATA_W  = VAL_W + WGT_W;
    localparam int NODE_W    = VAL_W + WGT_W;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // result codes
    localparam logic [STS_W-1:0] RES_STORED = 3'd0;
    localparam logic [STS_W-1:0] RES_DUP    = 3'd1;
    localparam logic [STS_W-1:0] RES_FULL   = 3'd2;
    localparam logic [STS_W-1:0] RES_HIT    = 3'd3;
    localparam logic [STS_W-1:0] RES_END    = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_NEWEST,
        S_LINK,
        S_WALK,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_HEAD,
        WR_FRESH,
        WR_HEADLINK
    } t_wr_kind;

    typedef struct packed {
        logic              load_item;
        logic              rd_en;
        logic              rd_from_in;
        t_wr_kind          wr_kind;
        logic              cnt_clr;
        logic              cnt_inc;
        logic              newest_ld;
        logic              res_ld;
        logic [STS_W-1:0]  res_code;
        logic              out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic bucket_bad;
        logic head_empty;
        logic val_match;
        logic pos_hit;
        logic link_is_head;
        logic pool_full;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> src/bucketed_list_pool.sv
// Bucketed list pool: 1024 bucket heads plus 7168 overflow nodes, each bucket a ring
// that runs from its head newest first. After reset the block clears the head values
// and takes no beat until that pass is done. An item then settles at the head (insert
// into an empty head, duplicate of the head, bad bucket, read of position 0 or of an
// empty head), stops at the newest node (insert that is a duplicate of it or finds a
// full pool), allocates a node (any other insert), or walks the ring (read of position n
// or one that runs off the ring after n links): each link costs one registered read of
// the node and link memories. The result sits in an output register, so the next item
// is accepted while it waits to be taken.
// depends on blp_pkg, blp_ctrl, blp_dp, blp_ram
`timescale 1ns / 1ps
`default_nettype none

module bucketed_list_pool (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // bucket[9:0], value_in[41:10], weight_in[73:42], position[86:74], zero pad [87]
    input  wire logic [blp_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // operation[0]
    input  wire logic                         i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    // value_out[31:0], weight_out[63:32]
    output logic      [blp_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // status[2:0]
    output logic      [blp_pkg::STS_W-1:0]    o_m_axis_tuser
);

    blp_pkg::t_dp_cmd cmd;
    blp_pkg::t_dp_sts sts;

    blp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    blp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

`default_nettype wire

>>> src/blp_ram.sv
// blp_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module blp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/blp_ctrl.sv
// blp_ctrl: sequencer for head clearing, insert and list walk
// depends on blp_pkg; drives blp_dp through t_dp_cmd and reads t_dp_sts
`timescale 1ns / 1ps
`default_nettype none

module blp_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire blp_pkg::t_dp_sts i_sts,
    output blp_pkg::t_dp_cmd     o_cmd
);

    blp_pkg::t_state r_state;
    blp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        o_cmd           = '0;
        o_cmd.wr_kind   = blp_pkg::WR_NONE;
        o_cmd.res_code  = blp_pkg::RES_END;

        case (r_state)
            blp_pkg::S_CLEAR: begin
                o_cmd.wr_kind = blp_pkg::WR_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = blp_pkg::S_IDLE;
                end
            end
            blp_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load_item  = 1'b1;
                    o_cmd.rd_en      = 1'b1;
                    o_cmd.rd_from_in = 1'b1;
                    o_cmd.cnt_clr    = 1'b1;
                    n_state          = blp_pkg::S_HEAD;
                end
            end
            blp_pkg::S_HEAD: begin
                if (i_sts.bucket_bad) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = i_sts.is_read ? blp_pkg::RES_END : blp_pkg::RES_FULL;
                    n_state        = blp_pkg::S_RESP;
                end else if (i_sts.is_read) begin
                    if (i_sts.head_empty) begin
                        o_cmd.res_ld   = 1'b1;
                        o_cmd.res_code = blp_pkg::RES_END;
                        n_state        = blp_pkg::S_RESP;
                    end else if (i_sts.pos_hit) begin
                        o_cmd.res_ld   = 1'b1;
                        o_cmd.res_code = blp_pkg::RES_HIT;
                        n_state        = blp_pkg::S_RESP;
                    end else if (i_sts.link_is_head) begin
                        o_cmd.res_ld   = 1'b1;
                        o_cmd.res_code = blp_pkg::RES_END;
                        n_state        = blp_pkg::S_RESP;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = blp_pkg::S_WALK;
                    end
                end else if (i_sts.head_empty) begin
                    o_cmd.wr_kind  = blp_pkg::WR_HEAD;
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = blp_pkg::RES_STORED;
                    n_state        = blp_pkg::S_RESP;
                end else if (i_sts.val_match) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = blp_pkg::RES_DUP;
                    n_state        = blp_pkg::S_RESP;
                end else begin
                    // fetch the newest node behind the head
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.newest_ld = 1'b1;
                    n_state         = blp_pkg::S_NEWEST;
                end
            end
            blp_pkg::S_NEWEST: begin
                if (i_sts.val_match) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = blp_pkg::RES_DUP;
                    n_state        = blp_pkg::S_RESP;
                end else if (i_sts.pool_full) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = blp_pkg::RES_FULL;
                    n_state        = blp_pkg::S_RESP;
                end else begin
                    o_cmd.wr_kind = blp_pkg::WR_FRESH;
                    n_state       = blp_pkg::S_LINK;
                end
            end
            blp_pkg::S_LINK: begin
                o_cmd.wr_kind  = blp_pkg::WR_HEADLINK;
                o_cmd.res_ld   = 1'b1;
                o_cmd.res_code = blp_pkg::RES_STORED;
                n_state        = blp_pkg::S_RESP;
            end
            blp_pkg::S_WALK: begin
                if (i_sts.pos_hit) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = blp_pkg::RES_HIT;
                    n_state        = blp_pkg::S_RESP;
                end else if (i_sts.link_is_head) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = blp_pkg::RES_END;
                    n_state        = blp_pkg::S_RESP;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            blp_pkg::S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = blp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = blp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/blp_dp.sv
// blp_dp: item registers, node and link memories, bump pointer and result register
// depends on blp_pkg and blp_ram; steered by blp_ctrl
`timescale 1ns / 1ps
`default_nettype none

module blp_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [blp_pkg::S_DATA_W-1:0]     i_s_axis_tdata,
    input  wire logic                             i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic      [blp_pkg::M_DATA_W-1:0]     o_m_axis_tdata,
    output logic      [blp_pkg::STS_W-1:0]        o_m_axis_tuser,
    input  wire blp_pkg::t_dp_cmd                 i_cmd,
    output blp_pkg::t_dp_sts                      o_sts
);

    localparam int AW = blp_pkg::ADDR_W;

    // latched item
    logic                        r_op;
    logic [blp_pkg::BKT_W-1:0]   r_bucket;
    logic [blp_pkg::VAL_W-1:0]   r_value;
    logic [blp_pkg::WGT_W-1:0]   r_weight;
    logic [blp_pkg::POS_W-1:0]   r_pos;

    logic [blp_pkg::NFREE_W-1:0] r_nfree;
    logic [blp_pkg::HEAD_W-1:0]  r_clr;
    logic [blp_pkg::POS_W-1:0]   r_cnt;
    logic [AW-1:0]               r_newest;

    logic [blp_pkg::STS_W-1:0]   r_res_code;
    logic [blp_pkg::VAL_W-1:0]   r_res_value;
    logic [blp_pkg::WGT_W-1:0]   r_res_weight;

    logic                        r_out_valid;
    logic [blp_pkg::STS_W-1:0]   r_out_code;
    logic [blp_pkg::VAL_W-1:0]   r_out_value;
    logic [blp_pkg::WGT_W-1:0]   r_out_weight;

    logic [blp_pkg::NODE_W-1:0]  node_rdata;
    logic [AW-1:0]               link_rdata;
    logic [blp_pkg::VAL_W-1:0]   rd_value;
    logic [blp_pkg::WGT_W-1:0]   rd_weight;

    logic [AW-1:0]               rd_addr;
    logic                        node_we;
    logic [AW-1:0]               node_waddr;
    logic [blp_pkg::NODE_W-1:0]  node_wdata;
    logic                        link_we;
    logic [AW-1:0]               link_waddr;
    logic [AW-1:0]               link_wdata;
    logic [AW-1:0]               head_addr;
    logic [AW-1:0]               fresh_addr;
    logic [blp_pkg::BKT_W-1:0]   in_bucket;
    logic                        out_free;

    assign rd_value   = node_rdata[blp_pkg::VAL_W-1:0];
    assign rd_weight  = node_rdata[blp_pkg::NODE_W-1:blp_pkg::VAL_W];
    assign head_addr  = AW'(r_bucket);
    assign fresh_addr = r_nfree[AW-1:0];
    assign in_bucket  = i_s_axis_tdata[blp_pkg::BKT_LSB +: blp_pkg::BKT_W];
    assign out_free   = !r_out_valid || i_m_axis_tready;

    assign rd_addr = i_cmd.rd_from_in ? AW'(in_bucket) : link_rdata;

    always_comb begin
        node_we    = 1'b0;
        node_waddr = head_addr;
        node_wdata = {r_weight, r_value};
        link_we    = 1'b0;
        link_waddr = head_addr;
        link_wdata = head_addr;
        case (i_cmd.wr_kind)
            blp_pkg::WR_CLEAR: begin
                // only head values need clearing, overflow nodes are written before use
                node_we    = 1'b1;
                node_waddr = AW'(r_clr);
                node_wdata = '0;
            end
            blp_pkg::WR_HEAD: begin
                node_we = 1'b1;
                link_we = 1'b1;
            end
            blp_pkg::WR_FRESH: begin
                node_we    = 1'b1;
                node_waddr = fresh_addr;
                link_we    = 1'b1;
                link_waddr = fresh_addr;
                link_wdata = r_newest;
            end
            blp_pkg::WR_HEADLINK: begin
                link_we    = 1'b1;
                link_wdata = fresh_addr;
            end
            default: begin
                node_we = 1'b0;
                link_we = 1'b0;
            end
        endcase
    end

    blp_ram #(
        .WIDTH (blp_pkg::NODE_W),
        .DEPTH (blp_pkg::POOL)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (node_rdata)
    );

    blp_ram #(
        .WIDTH (AW),
        .DEPTH (blp_pkg::POOL)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (link_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op     <= i_s_axis_tuser;
            r_bucket <= in_bucket;
            r_value  <= i_s_axis_tdata[blp_pkg::VAL_LSB +: blp_pkg::VAL_W];
            r_weight <= i_s_axis_tdata[blp_pkg::WGT_LSB +: blp_pkg::WGT_W];
            r_pos    <= i_s_axis_tdata[blp_pkg::POS_LSB +: blp_pkg::POS_W];
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.newest_ld) begin
            r_newest <= link_rdata;
        end
        if (i_cmd.res_ld) begin
            r_res_code   <= i_cmd.res_code;
            r_res_value  <= (i_cmd.res_code == blp_pkg::RES_HIT) ? rd_value : '0;
            r_res_weight <= (i_cmd.res_code == blp_pkg::RES_HIT) ? rd_weight : '0;
        end
        if (i_cmd.out_load) begin
            r_out_code   <= r_res_code;
            r_out_value  <= r_res_value;
            r_out_weight <= r_res_weight;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfree     <= blp_pkg::NFREE_W'(blp_pkg::HEADS);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_kind == blp_pkg::WR_HEADLINK) begin
                r_nfree <= r_nfree + 1'b1;
            end
            if (i_cmd.wr_kind == blp_pkg::WR_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last     = (r_clr == blp_pkg::HEAD_W'(blp_pkg::HEADS - 1));
    assign o_sts.is_read      = (r_op == blp_pkg::OP_READ);
    assign o_sts.bucket_bad   = (32'(r_bucket) >= 32'(blp_pkg::HEADS));
    assign o_sts.head_empty   = (rd_value == '0);
    assign o_sts.val_match    = (rd_value == r_value);
    assign o_sts.pos_hit      = (r_cnt == r_pos);
    assign o_sts.link_is_head = (link_rdata == head_addr);
    assign o_sts.pool_full    = (r_nfree >= blp_pkg::NFREE_W'(blp_pkg::POOL));
    assign o_sts.out_free     = out_free;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_weight, r_out_value};
    assign o_m_axis_tuser  = r_out_code;

    a_nfree_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfree >= blp_pkg::NFREE_W'(blp_pkg::HEADS))
        && (r_nfree <= blp_pkg::NFREE_W'(blp_pkg::POOL)))
        else $error("bump pointer out of range");

    a_fresh_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_kind == blp_pkg::WR_FRESH) |-> !o_sts.pool_full)
        else $error("overflow node written into a full pool");

    a_headlink_follows_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_kind == blp_pkg::WR_FRESH) |=> (i_cmd.wr_kind == blp_pkg::WR_HEADLINK))
        else $error("fresh node not linked behind its head");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result register overwritten before it was taken");

    a_nfree_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfree != $past(r_nfree)) |-> (r_nfree == $past(r_nfree) + 1'b1))
        else $error("bump pointer moved by more than one");

endmodule

`default_nettype wire
